// ===== sv/sorted_run_fence_lookup_unit_defines.svh =====
// ----------------------------------------------------------------------------
// sorted run fence lookup: assertion macros
// shared assertion forms for the lookup unit, clocked on the rising edge
// ----------------------------------------------------------------------------
`ifndef SORTED_RUN_FENCE_LOOKUP_UNIT_DEFINES_SVH
`define SORTED_RUN_FENCE_LOOKUP_UNIT_DEFINES_SVH

// checked only while out of reset
`define SRFL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked at every edge, reset included
`define SRFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/srfl_pkg.sv =====
// ----------------------------------------------------------------------------
// srfl_pkg
// shared constants, codes and types of the sorted run fence lookup unit
// ----------------------------------------------------------------------------
package srfl_pkg;

  // default sizes
  localparam int unsigned RUN_CAPACITY_DEF = 1024;
  localparam int unsigned PAGE_ENTRIES_DEF = 64;
  localparam int unsigned KEY_BITS_DEF     = 32;
  localparam int unsigned VALUE_BITS_DEF   = 32;

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_RUN_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FENCE_RD,
    ST_FENCE_CHK,
    ST_SETUP,
    ST_SEARCH_RD,
    ST_SEARCH_CHK,
    ST_RESP
  } state_e;

endpackage

// ===== sv/srfl_ram.sv =====
// ----------------------------------------------------------------------------
// srfl_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module srfl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/sorted_run_fence_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_run_fence_lookup_unit
// one sorted run of key-value pairs with fence keys and a paged binary search
// ----------------------------------------------------------------------------
// The unit stores one run of up to RUN_CAPACITY key-value pairs, which the
// user must append in ascending key order (the unit does not enforce it), and
// answers one word per command word. Clear and append act in the idle step
// and hand the result to the output register from the response step. A
// lookup is run by a small sequencer over two memories, each with one
// registered read port: it walks the fence table one fence key at a time
// (read, then check), then binary-searches the chosen page one probe at a
// time (read, then check). The number of fence keys probed is at most the
// number of pages in use, and the number of search probes at most
// ceil(log2(PAGE_ENTRIES+1)). A miss on an empty run or on a key above the
// largest key goes from the idle step straight to the response step; a key
// below the first fence key is answered after the first fence check. The unit
// takes no new word until the current one has reached the output register,
// and it may take the next word while that result still waits to be read.
// ----------------------------------------------------------------------------
module sorted_run_fence_lookup_unit #(
  parameter int unsigned RUN_CAPACITY = srfl_pkg::RUN_CAPACITY_DEF,
  parameter int unsigned PAGE_ENTRIES = srfl_pkg::PAGE_ENTRIES_DEF,
  parameter int unsigned KEY_BITS     = srfl_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS   = srfl_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   command_i,
  input  logic signed [KEY_BITS-1:0]   key_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  // result words
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status_o,
  output logic signed [VALUE_BITS-1:0] found_value_o
);

  import srfl_pkg::*;

`include "sorted_run_fence_lookup_unit_defines.svh"

  // sizes derived from the parameters
  localparam int unsigned FENCE_DEPTH = (RUN_CAPACITY + PAGE_ENTRIES - 1) / PAGE_ENTRIES;
  localparam int unsigned AW  = $clog2(RUN_CAPACITY);          // entry address
  localparam int unsigned CW  = $clog2(RUN_CAPACITY + 1);      // entry count
  localparam int unsigned FAW = (FENCE_DEPTH > 1) ? $clog2(FENCE_DEPTH) : 1;
  localparam int unsigned FCW = $clog2(FENCE_DEPTH + 1);       // fence count
  localparam int unsigned PW  = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
  localparam int unsigned BW  = $clog2(RUN_CAPACITY + PAGE_ENTRIES + 1);
  localparam int unsigned DW  = KEY_BITS + VALUE_BITS;

  // sequencer and run state
  state_e                         state_q, state_d;
  logic [CW-1:0]                  count_q, count_d;
  logic [FCW-1:0]                 fcnt_q, fcnt_d;     // fence keys written
  logic [PW-1:0]                  page_off_q, page_off_d;
  logic signed [KEY_BITS-1:0]     largest_q, largest_d;

  // lookup working registers
  logic signed [KEY_BITS-1:0]     key_q, key_d;
  logic [FCW-1:0]                 fidx_q, fidx_d;     // fence being probed
  logic [FCW-1:0]                 page_q, page_d;     // last fence not above key
  logic [CW-1:0]                  base_q, base_d;     // first entry of that page
  logic [CW-1:0]                  lo_q, lo_d;
  logic [CW-1:0]                  hi_q, hi_d;
  logic [CW-1:0]                  mid_q, mid_d;

  // pending result and output register
  logic [1:0]                     res_status_q, res_status_d;
  logic [VALUE_BITS-1:0]          res_value_q, res_value_d;
  logic                           out_valid_q, out_valid_d;
  logic [1:0]                     status_q, status_d;
  logic [VALUE_BITS-1:0]          found_q, found_d;

  // memory ports
  logic                           kv_we;
  logic [AW-1:0]                  kv_raddr;
  logic [DW-1:0]                  kv_rdata;
  logic                           fence_we;
  logic [FAW-1:0]                 fence_raddr;
  logic [KEY_BITS-1:0]            fence_rdata;

  logic                           in_fire;
  logic                           out_free;
  logic signed [KEY_BITS-1:0]     fence_key;
  logic signed [KEY_BITS-1:0]     probe_key;
  logic [FCW:0]                   fidx_next;
  logic [BW-1:0]                  page_end;
  logic [CW-1:0]                  span;

  assign in_ready  = (state_q == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_q || out_ready;

  assign fence_key = $signed(fence_rdata);
  assign probe_key = $signed(kv_rdata[KEY_BITS-1:0]);
  assign fidx_next = (FCW+1)'(fidx_q) + (FCW+1)'(1);
  assign page_end  = BW'(base_q) + BW'(PAGE_ENTRIES);
  assign span      = hi_q - lo_q;

  // key and value share one entry of the run store
  srfl_ram #(
    .WIDTH (DW),
    .DEPTH (RUN_CAPACITY),
    .AW    (AW)
  ) u_kv_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({value_i, key_i}),
    .raddr_i (kv_raddr),
    .rdata_o (kv_rdata)
  );

  // first key of each page
  srfl_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (FENCE_DEPTH),
    .AW    (FAW)
  ) u_fence_ram (
    .clk_i   (clk_i),
    .we_i    (fence_we),
    .waddr_i (fcnt_q[FAW-1:0]),
    .wdata_i (key_i),
    .raddr_i (fence_raddr),
    .rdata_o (fence_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    fcnt_d       = fcnt_q;
    page_off_d   = page_off_q;
    largest_d    = largest_q;
    key_d        = key_q;
    fidx_d       = fidx_q;
    page_d       = page_q;
    base_d       = base_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && !out_ready;
    status_d     = status_q;
    found_d      = found_q;
    kv_we        = 1'b0;
    fence_we     = 1'b0;
    kv_raddr     = mid_q[AW-1:0];
    fence_raddr  = fidx_q[FAW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          key_d        = key_i;
          res_value_d  = '0;
          res_status_d = STATUS_OK;
          state_d      = ST_RESP;
          unique case (command_i)
            CMD_CLEAR: begin
              count_d    = '0;
              fcnt_d     = '0;
              page_off_d = '0;
              largest_d  = {1'b1, {(KEY_BITS-1){1'b0}}};
            end
            CMD_APPEND: begin
              if (count_q == CW'(RUN_CAPACITY)) begin
                res_status_d = STATUS_RUN_FULL;
              end else begin
                kv_we   = 1'b1;
                count_d = count_q + CW'(1);
                // the first entry of every page becomes a fence key
                if (page_off_q == '0) begin
                  fence_we = 1'b1;
                  fcnt_d   = fcnt_q + FCW'(1);
                end
                page_off_d = (page_off_q == PW'(PAGE_ENTRIES - 1)) ? '0
                                                                   : page_off_q + PW'(1);
                if (key_i > largest_q) begin
                  largest_d = key_i;
                end
              end
            end
            CMD_LOOKUP: begin
              if (count_q == '0 || key_i > largest_q) begin
                res_status_d = STATUS_NOT_FOUND;
              end else begin
                fidx_d  = '0;
                page_d  = '0;
                base_d  = '0;
                state_d = ST_FENCE_RD;
              end
            end
            default: begin
              res_status_d = STATUS_NOT_FOUND;
            end
          endcase
        end
      end

      ST_FENCE_RD: begin
        state_d = ST_FENCE_CHK;
      end

      ST_FENCE_CHK: begin
        if (fidx_q == '0 && key_q < fence_key) begin
          // below the first fence key
          res_status_d = STATUS_NOT_FOUND;
          state_d      = ST_RESP;
        end else if (fidx_q != '0 && fence_key > key_q) begin
          state_d = ST_SETUP;
        end else begin
          if (fidx_q != '0) begin
            page_d = fidx_q;
            base_d = base_q + CW'(PAGE_ENTRIES);
          end
          if (fidx_next < (FCW+1)'(fcnt_q)) begin
            fidx_d  = fidx_next[FCW-1:0];
            state_d = ST_FENCE_RD;
          end else begin
            state_d = ST_SETUP;
          end
        end
      end

      ST_SETUP: begin
        // page end is exclusive: next page start, or run end on the last page
        lo_d = base_q;
        if ((FCW+1)'(page_q) + (FCW+1)'(1) == (FCW+1)'(fcnt_q)) begin
          hi_d = count_q;
        end else begin
          hi_d = page_end[CW-1:0];
        end
        state_d = ST_SEARCH_RD;
      end

      ST_SEARCH_RD: begin
        if (lo_q < hi_q) begin
          mid_d    = lo_q + (span >> 1);
          kv_raddr = mid_d[AW-1:0];
          state_d  = ST_SEARCH_CHK;
        end else begin
          res_status_d = STATUS_NOT_FOUND;
          state_d      = ST_RESP;
        end
      end

      ST_SEARCH_CHK: begin
        if (probe_key == key_q) begin
          res_status_d = STATUS_OK;
          res_value_d  = kv_rdata[DW-1:KEY_BITS];
          state_d      = ST_RESP;
        end else begin
          if (probe_key < key_q) begin
            lo_d = mid_q + CW'(1);
          end else begin
            hi_d = mid_q;
          end
          state_d = ST_SEARCH_RD;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          found_d     = res_value_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      fcnt_q       <= '0;
      page_off_q   <= '0;
      largest_q    <= {1'b1, {(KEY_BITS-1){1'b0}}};
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      fcnt_q       <= fcnt_d;
      page_off_q   <= page_off_d;
      largest_q    <= largest_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    fidx_q       <= fidx_d;
    page_q       <= page_d;
    base_q       <= base_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    status_q     <= status_d;
    found_q      <= found_d;
  end

  assign out_valid     = out_valid_q;
  assign status_o      = status_q;
  assign found_value_o = $signed(found_q);

  // run never grows past its capacity
  `SRFL_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(RUN_CAPACITY), "entry count overflow")
  // fence count is zero exactly when the run is empty
  `SRFL_ASSERT(a_fence_count, clk_i, rst_ni, (fcnt_q == '0) == (count_q == '0), "fence count mismatch")
  // a search probe only reads stored entries
  `SRFL_ASSERT(a_probe_bound, clk_i, rst_ni, state_q == ST_SEARCH_CHK |-> mid_q < count_q, "probe beyond run end")
  // an accepted word leaves the unit busy in the cycle after acceptance
  `SRFL_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_fire |=> !in_ready, "ready right after accept")
  // a result is loaded only from the response step
  `SRFL_ASSERT(a_load_from_resp, clk_i, rst_ni, (!out_valid_q || out_ready) && $past(state_q) != ST_RESP && !$past(out_valid_q) |-> !out_valid_q, "result without response step")

endmodule
